@@ design/ssc_pkg.sv @@
package ssc_pkg;

    localparam int AngW = 24;
    localparam int CordicStagesDef = 16;
    localparam int MaxStages = 32;

    localparam logic signed [AngW-1:0] PiQ      = 24'sd205887;
    localparam logic signed [AngW-1:0] HalfPiQ  = 24'sd102944;
    localparam logic signed [AngW-1:0] TwoPiQ   = 24'sd411775;
    localparam logic signed [AngW-1:0] CordicKQ = 24'sd39797;

    localparam logic signed [19:0] CosZenithQ = -20'sd953;
    localparam logic signed [17:0] DeclAmpQ   = 18'sd26804;
    localparam logic signed [21:0] EqSinQ     = 22'sd646840;
    localparam logic signed [21:0] EqCosQ     = 22'sd493486;
    localparam logic signed [21:0] RadPerCdegQ32 = 22'sd749613;
    localparam logic signed [28:0] RadPerDayQ32  = 29'sd73934453;
    localparam logic signed [28:0] MinPerCdegQ32 = 29'sd171798692;
    localparam logic signed [25:0] MinPerRadQ16  = 26'sd15019745;

    localparam logic [14:0] LatReset = 15'd3990;
    localparam logic [15:0] LonReset = 16'd3280;
    localparam logic [10:0] UtcReset = 11'd180;

    localparam logic [1:0] RegLat = 2'd0;
    localparam logic [1:0] RegLon = 2'd1;
    localparam logic [1:0] RegUtc = 2'd2;

    localparam logic signed [12:0] OutMin = -13'sd2048;
    localparam logic signed [12:0] OutMax = 13'sd4095;

    // sincos front fold result
    typedef struct packed {
        logic signed [AngW-1:0] r;
        logic                   neg;
    } t_fold;

    function automatic logic signed [AngW-1:0] atan_tab(input int k);
        logic signed [AngW-1:0] t;
        begin
            case (k)
                0: t = 24'sd51472;
                1: t = 24'sd30386;
                2: t = 24'sd16055;
                3: t = 24'sd8150;
                4: t = 24'sd4091;
                5: t = 24'sd2047;
                6: t = 24'sd1024;
                7: t = 24'sd512;
                8: t = 24'sd256;
                9: t = 24'sd128;
                10: t = 24'sd64;
                11: t = 24'sd32;
                12: t = 24'sd16;
                13: t = 24'sd8;
                14: t = 24'sd4;
                15: t = 24'sd2;
                16: t = 24'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // c99 remainder by 2*pi then fold into [-pi/2, pi/2]; |ang| < 8*pi here
    function automatic t_fold fold_angle(input logic signed [AngW-1:0] ang);
        logic signed [AngW-1:0] r;
        t_fold f;
        begin
            r = ang;
            for (int i = 0; i < 3; i++) begin
                if (r >= TwoPiQ) r = r - TwoPiQ;
                else if (r <= -TwoPiQ) r = r + TwoPiQ;
            end
            if (r > PiQ) r = r - TwoPiQ;
            if (r < -PiQ) r = r + TwoPiQ;
            f.neg = 1'b0;
            if (r > HalfPiQ) begin
                r = r - PiQ;
                f.neg = 1'b1;
            end else if (r < -HalfPiQ) begin
                r = r + PiQ;
                f.neg = 1'b1;
            end
            f.r = r;
            return f;
        end
    endfunction

endpackage

@@ design/ssc_pipe.sv @@
// generic stall-able delay line of data
module ssc_pipe #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_q [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= i_d;
            for (int i = 1; i < D; i++) r_q[i] <= r_q[i-1];
        end
    end

    assign o_q = r_q[D-1];
endmodule

@@ design/ssc_sincos.sv @@
// rotation-mode cordic, one register stage per iteration
module ssc_sincos #(
    parameter int CORDIC_STAGES = ssc_pkg::CordicStagesDef
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [ssc_pkg::AngW-1:0] i_ang,
    output logic signed [ssc_pkg::AngW-1:0] o_sin,
    output logic signed [ssc_pkg::AngW-1:0] o_cos
);
    localparam int W = ssc_pkg::AngW;

    logic signed [W-1:0] r_x [CORDIC_STAGES+1];
    logic signed [W-1:0] r_y [CORDIC_STAGES+1];
    logic signed [W-1:0] r_z [CORDIC_STAGES+1];
    logic                r_neg [CORDIC_STAGES+1];
    ssc_pkg::t_fold      f;

    assign f = ssc_pkg::fold_angle(i_ang);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= ssc_pkg::CordicKQ;
            r_y[0]   <= '0;
            r_z[0]   <= f.r;
            r_neg[0] <= f.neg;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_neg[i+1] <= r_neg[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> (i % 32));
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> (i % 32));
                    r_z[i+1] <= r_z[i] - ssc_pkg::atan_tab(i % 32);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> (i % 32));
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> (i % 32));
                    r_z[i+1] <= r_z[i] + ssc_pkg::atan_tab(i % 32);
                end
            end
        end
    end

    assign o_sin = r_neg[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
    assign o_cos = r_neg[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
endmodule

@@ design/ssc_acos.sv @@
// pipelined isqrt (one result bit per stage) then vectoring cordic atan2
module ssc_acos #(
    parameter int CORDIC_STAGES = ssc_pkg::CordicStagesDef
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [19:0] i_c,
    input  logic        [19:0] i_d,
    output logic signed [ssc_pkg::AngW-1:0] o_h
);
    localparam int W  = ssc_pkg::AngW;
    localparam int SQ = 20;

    logic [39:0]        r_v   [SQ+1];
    logic [39:0]        r_res [SQ+1];
    logic signed [19:0] r_c   [SQ+1];
    logic signed [W-1:0] r_x [CORDIC_STAGES+1];
    logic signed [W-1:0] r_y [CORDIC_STAGES+1];
    logic signed [W-1:0] r_z [CORDIC_STAGES+1];
    logic [39:0] diff;
    logic signed [W-1:0] c_ext, s_ext;

    assign diff  = 40'(i_d) * 40'(i_d) - 40'($unsigned(40'(i_c) * 40'(i_c)));
    assign c_ext = W'(r_c[SQ]);
    assign s_ext = W'(r_res[SQ]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v[0]   <= diff;
            r_res[0] <= '0;
            r_c[0]   <= i_c;
            for (int i = 0; i < SQ; i++) begin
                r_c[i+1] <= r_c[i];
                if (r_v[i] >= r_res[i] + (40'd1 << (2*(SQ-1-i)))) begin
                    r_v[i+1]   <= r_v[i] - (r_res[i] + (40'd1 << (2*(SQ-1-i))));
                    r_res[i+1] <= (r_res[i] >> 1) + (40'd1 << (2*(SQ-1-i)));
                end else begin
                    r_v[i+1]   <= r_v[i];
                    r_res[i+1] <= r_res[i] >> 1;
                end
            end
            if (c_ext < 0) begin
                r_x[0] <= s_ext;
                r_y[0] <= -c_ext;
                r_z[0] <= ssc_pkg::HalfPiQ;
            end else begin
                r_x[0] <= c_ext;
                r_y[0] <= s_ext;
                r_z[0] <= '0;
            end
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> (i % 32));
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> (i % 32));
                    r_z[i+1] <= r_z[i] + ssc_pkg::atan_tab(i % 32);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> (i % 32));
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> (i % 32));
                    r_z[i+1] <= r_z[i] - ssc_pkg::atan_tab(i % 32);
                end
            end
        end
    end

    assign o_h = r_z[CORDIC_STAGES];
endmodule

@@ design/sunrise_sunset_calculator.sv @@
// path from input beat to output beat: three cordic chains of CORDIC_STAGES + 1 stages,
// a 21-stage square root and seven arithmetic stages
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// reset: synchronous active-low i_rst_n clears all valid bits and loads the site
// registers with latitude 39.90, longitude 32.80, utc offset 180 minutes
module sunrise_sunset_calculator #(
    parameter int CORDIC_STAGES = ssc_pkg::CordicStagesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [8:0] day_of_year
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] no_event, [13:1] sunrise_minute, [26:14] sunset_minute
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int W   = ssc_pkg::AngW;
    localparam int LAT = 1 + 2 * (CORDIC_STAGES + 1) + 1 + 2 + 20 + CORDIC_STAGES + 1 + 2 + 2;

    logic signed [14:0] r_lat;
    logic signed [15:0] r_lon;
    logic signed [10:0] r_utc;
    logic [LAT-1:0] r_vld;
    logic en;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat <= ssc_pkg::LatReset;
            r_lon <= ssc_pkg::LonReset;
            r_utc <= ssc_pkg::UtcReset;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ssc_pkg::RegLat: r_lat <= i_cfg_data[14:0];
                    ssc_pkg::RegLon: r_lon <= i_cfg_data;
                    ssc_pkg::RegUtc: r_utc <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: angles
    logic signed [W-1:0] r1_a1, r1_a2, r1_lat;
    logic signed [9:0]   dd;
    logic signed [40:0]  p_a1, p_lat;
    assign dd    = $signed({1'b0, s_axis_tdata[8:0]}) - 10'sd81;
    assign p_a1  = 41'(dd) * 41'(ssc_pkg::RadPerDayQ32);
    assign p_lat = 41'(r_lat) * 41'(ssc_pkg::RadPerCdegQ32);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a1  <= W'((p_a1 + 41'sd32768) >>> 16);
            r1_a2  <= W'(((p_a1 <<< 1) + 41'sd32768) >>> 16);
            r1_lat <= W'((p_lat + 41'sd32768) >>> 16);
        end
    end

    // phase A: sin/cos of a1 and lat, sin of a2
    logic signed [W-1:0] sa1, ca1, sa2, sl, cl;
    ssc_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_a1 (.i_clk, .i_en(en), .i_ang(r1_a1), .o_sin(sa1), .o_cos(ca1));
    ssc_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_a2 (.i_clk, .i_en(en), .i_ang(r1_a2), .o_sin(sa2), .o_cos());
    ssc_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_lt (.i_clk, .i_en(en), .i_ang(r1_lat), .o_sin(sl), .o_cos(cl));

    // decl and eqtime product
    logic signed [W-1:0] r2_decl, r2_sl, r2_cl;
    logic signed [47:0]  r2_eq;
    logic signed [47:0]  p_decl;
    assign p_decl = 48'(ssc_pkg::DeclAmpQ) * 48'(sa1);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_decl <= W'((p_decl + 48'sd32768) >>> 16);
            r2_eq   <= 48'(ssc_pkg::EqSinQ) * 48'(sa2) - 48'(ssc_pkg::EqCosQ) * 48'(ca1);
            r2_sl   <= sl;
            r2_cl   <= cl;
        end
    end

    // carried values across the declination cordic
    localparam int CW = 2 * W + 48;
    logic [CW-1:0] car_b;
    logic signed [W-1:0] sl_b, cl_b;
    logic signed [47:0]  eq_b;
    ssc_pipe #(.W(CW), .D(CORDIC_STAGES + 1)) u_car1 (
        .i_clk, .i_en(en), .i_d({r2_sl, r2_cl, r2_eq}), .o_q(car_b));
    assign {sl_b, cl_b, eq_b} = car_b;

    logic signed [W-1:0] sd, cd;
    ssc_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_dc (.i_clk, .i_en(en), .i_ang(r2_decl), .o_sin(sd), .o_cos(cd));

    // num / den
    logic signed [47:0] r3_ps, r3_pc;
    logic signed [47:0] r3_eq;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ps <= 48'(sl_b) * 48'(sd);
            r3_pc <= 48'(cl_b) * 48'(cd);
            r3_eq <= eq_b;
        end
    end
    logic signed [31:0] num, den, cc, dn;
    assign num = 32'(ssc_pkg::CosZenithQ) - 32'((r3_ps + 48'sd32768) >>> 16);
    assign den = 32'((r3_pc + 48'sd32768) >>> 16);
    assign cc  = den < 0 ? -num : num;
    assign dn  = den < 0 ? -den : den;

    logic signed [19:0] r4_c;
    logic        [19:0] r4_d;
    logic               r4_ne;
    logic signed [W-1:0] r4_eq;
    logic signed [47:0] eqr;
    assign eqr = (r3_eq + 48'sd32768) >>> 16;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ne <= (dn == 0) || (cc > dn) || (cc < -dn);
            r4_c  <= 20'(cc);
            r4_d  <= 20'(dn);
            r4_eq <= W'(eqr);
        end
    end

    // square root load stage, 20 root stages, cordic load stage and its iterations
    localparam int DW = W + 1;
    logic [DW-1:0] car_d;
    logic signed [W-1:0] eq_d;
    logic ne_d;
    ssc_pipe #(.W(DW), .D(20 + CORDIC_STAGES + 2)) u_car2 (
        .i_clk, .i_en(en), .i_d({r4_ne, r4_eq}), .o_q(car_d));
    assign {ne_d, eq_d} = car_d;

    logic signed [W-1:0] h;
    ssc_acos #(.CORDIC_STAGES(CORDIC_STAGES)) u_ac (
        .i_clk, .i_en(en), .i_c(r4_c), .i_d(r4_d), .o_h(h));

    // hour angle minutes and noon
    logic signed [51:0] r5_hm, r5_lon;
    logic signed [W-1:0] r5_eq;
    logic signed [11:0] r5_utc;
    logic r5_ne;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_hm  <= 52'(h) * 52'(ssc_pkg::MinPerRadQ16);
            r5_lon <= 52'(r_lon) * 52'(ssc_pkg::MinPerCdegQ32);
            r5_eq  <= eq_d;
            r5_utc <= 12'(r_utc);
            r5_ne  <= ne_d;
        end
    end

    logic signed [39:0] r6_noon, r6_hm;
    logic r6_ne;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_hm   <= 40'((r5_hm + 52'sd32768) >>> 16);
            r6_noon <= (40'sd720 <<< 16) - 40'((r5_lon + 52'sd32768) >>> 16)
                       - 40'(r5_eq) + (40'(r5_utc) <<< 16);
            r6_ne   <= r5_ne;
        end
    end

    // truncate toward zero then saturate
    function automatic logic [12:0] to_min(input logic signed [39:0] v);
        logic signed [39:0] q;
        begin
            q = (v < 0) ? -((-v) >>> 16) : (v >>> 16);
            if (q < 40'(ssc_pkg::OutMin)) return ssc_pkg::OutMin;
            if (q > 40'sd4095) return ssc_pkg::OutMax;
            return q[12:0];
        end
    endfunction

    logic [12:0] r7_rise, r7_set;
    logic r7_ne;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ne   <= r6_ne;
            r7_rise <= r6_ne ? 13'h1FFF : to_min(r6_noon - r6_hm);
            r7_set  <= r6_ne ? 13'h1FFF : to_min(r6_noon + r6_hm);
        end
    end

    assign m_axis_tdata = {5'd0, r7_set, r7_rise, r7_ne};

    a_nostall_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output moved during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready mismatch");
    a_noevent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[26:1] == 26'h3FFFFFF)
        else $error("no_event without -1 times");
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int Stages = 16;
    localparam int Latency = 3 * Stages + 31;
    localparam int NDir = 24;
    localparam int NRand = 1250;

    // fixed point constants of the solar rule, q16 unless noted
    localparam longint QPi = 205887;
    localparam longint QHalfPi = 102944;
    localparam longint QTwoPi = 411775;
    localparam longint QGain = 39797;
    localparam longint QCosZen = -953;
    localparam longint QDeclAmp = 26804;
    localparam longint QEqSin = 646840;
    localparam longint QEqCos = 493486;
    localparam longint Q32RadCdeg = 749613;
    localparam longint Q32RadDay = 73934453;
    localparam longint Q32MinCdeg = 171798692;
    localparam longint QMinRad = 15019745;

    typedef struct {
        logic               no_event;
        logic signed [12:0] rise;
        logic signed [12:0] set;
    } t_sun_times;

    typedef struct {
        int   lat;
        int   lon;
        int   utc;
        int   day;
        bit   typed;
        t_sun_times want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [8:0] day_of_year
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [0] no_event, [13:1] sunrise, [26:14] sunset
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    sunrise_sunset_calculator #(.CORDIC_STAGES(Stages)) dut (.*);

    longint site_lat, site_lon, site_utc;
    longint atan_q [32];
    t_sun_times pending_times [$];
    int errors, mismatches, beats_in, beats_out, polar_seen, cfg_writes;
    int snd_pct, rcv_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("timeout after %0d beats out", beats_out);
        $display("sunrise_sunset_calculator verification failed");
        $finish;
    end

    function automatic longint rnd_q(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint r, x, y, dx, dy;
        bit neg;
        r = ang % QTwoPi;
        neg = 1'b0;
        x = QGain;
        y = 0;
        if (r > QPi) r -= QTwoPi;
        if (r < -QPi) r += QTwoPi;
        if (r > QHalfPi) begin
            r -= QPi;
            neg = 1'b1;
        end else if (r < -QHalfPi) begin
            r += QPi;
            neg = 1'b1;
        end
        for (int i = 0; i < Stages; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (r >= 0) begin
                x -= dx; y += dy; r -= atan_q[i & 31];
            end else begin
                x += dx; y -= dy; r += atan_q[i & 31];
            end
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        s = y;
        c = x;
    endtask

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint hour_angle(input longint y0, input longint x0);
        longint x, y, z, dx, dy, t;
        x = x0;
        y = y0;
        z = 0;
        if (x < 0) begin
            t = y; y = -x; x = t; z = QHalfPi;
        end
        for (int i = 0; i < Stages; i++) begin
            dx = y >>> (i & 31);
            dy = x >>> (i & 31);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_q[i & 31];
            end else begin
                x -= dx; y += dy; z -= atan_q[i & 31];
            end
        end
        return z;
    endfunction

    function automatic logic signed [12:0] clamp_min(input longint v);
        if (v < -2048) return -13'sd2048;
        if (v > 4095) return 13'sd4095;
        return v[12:0];
    endfunction

    task automatic predict_times(input logic [8:0] day, output t_sun_times r);
        longint dd, lat, a1, a2, sa1, ca1, sa2, ca2, sl, cl, sd, cd;
        longint decl, num, den, c, d, h, hm, eq, noon;
        dd = longint'(day) - 81;
        lat = rnd_q(site_lat * Q32RadCdeg, 16);
        a1 = rnd_q(dd * Q32RadDay, 16);
        a2 = rnd_q(dd * 2 * Q32RadDay, 16);
        cordic_sincos(a1, sa1, ca1);
        cordic_sincos(a2, sa2, ca2);
        cordic_sincos(lat, sl, cl);
        decl = rnd_q(QDeclAmp * sa1, 16);
        cordic_sincos(decl, sd, cd);
        num = QCosZen - rnd_q(sl * sd, 16);
        den = rnd_q(cl * cd, 16);
        c = (den < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (d == 0 || c > d || c < -d) begin
            r.no_event = 1'b1;
            r.rise = -13'sd1;
            r.set = -13'sd1;
        end else begin
            h = hour_angle(floor_sqrt(longint'(d * d - c * c)), c);
            hm = rnd_q(h * QMinRad, 16);
            eq = rnd_q(QEqSin * sa2 - QEqCos * ca1, 16);
            noon = 720 * 65536 - rnd_q(site_lon * Q32MinCdeg, 16) - eq + site_utc * 65536;
            r.no_event = 1'b0;
            r.rise = clamp_min((noon - hm) / 65536);
            r.set = clamp_min((noon + hm) / 65536);
        end
    endtask

    // receiver side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= rcv_pct);
    end

    always @(posedge i_clk) begin
        t_sun_times got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            got.no_event = m_axis_tdata[0];
            got.rise = m_axis_tdata[13:1];
            got.set = m_axis_tdata[26:14];
            if (pending_times.size() == 0) begin
                errors++;
                $display("output beat with nothing expected: %h", m_axis_tdata);
            end else begin
                want = pending_times.pop_front();
                if (got.no_event) polar_seen++;
                if (got.no_event !== want.no_event || got.rise !== want.rise ||
                    got.set !== want.set) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch beat %0d: want %b/%0d/%0d got %b/%0d/%0d",
                                 beats_out, want.no_event, want.rise, want.set,
                                 got.no_event, got.rise, got.set);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_times.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value[15:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
        case (idx)
            ssc_pkg::RegLat: site_lat = longint'($signed(i_cfg_data[14:0]));
            ssc_pkg::RegLon: site_lon = longint'($signed(i_cfg_data[15:0]));
            ssc_pkg::RegUtc: site_utc = longint'($signed(i_cfg_data[10:0]));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_site(input int lat, input int lon, input int utc);
        wait_drained();
        write_reg(ssc_pkg::RegLat, lat);
        write_reg(ssc_pkg::RegLon, lon);
        write_reg(ssc_pkg::RegUtc, utc);
    endtask

    task automatic send_day(input logic [8:0] day, input bit typed, input t_sun_times typed_r);
        t_sun_times r;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'b0, day};
        do @(posedge i_clk); while (!s_axis_tready);
        if (typed) r = typed_r;
        else predict_times(day, r);
        pending_times.push_back(r);
        beats_in++;
    endtask

    // each idle cycle is drawn on its own
    task automatic sender_gap();
        while ($urandom_range(99) < snd_pct) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
    endtask

    function automatic int pick(input int lo, input int hi, input int width);
        int k;
        k = $urandom_range(99);
        if (k < 10) return lo;
        if (k < 20) return hi;
        if (k < 28) return int'($urandom_range((1 << width) - 1));
        return lo + int'($urandom_range(hi - lo));
    endfunction

    localparam t_sun_times Polar = '{1'b1, -13'sd1, -13'sd1};
    localparam t_sun_times NoT = '{1'b0, 13'sd0, 13'sd0};

    t_dir_row dir_tbl [NDir] = '{
        '{3990, 3280, 180, 1, 0, NoT},
        '{3990, 3280, 180, 81, 0, NoT},
        '{3990, 3280, 180, 172, 0, NoT},
        '{3990, 3280, 180, 266, 0, NoT},
        '{3990, 3280, 180, 355, 0, NoT},
        '{3990, 3280, 180, 366, 0, NoT},
        '{3990, 3280, 180, 0, 0, NoT},
        '{3990, 3280, 180, 511, 0, NoT},
        '{9000, 0, 0, 172, 1, Polar},
        '{9000, 0, 0, 355, 1, Polar},
        '{-9000, 0, 0, 172, 1, Polar},
        '{0, 0, 0, 1, 0, NoT},
        '{0, 0, 0, 172, 0, NoT},
        '{6700, 2500, 120, 172, 0, NoT},
        '{6700, 2500, 120, 355, 0, NoT},
        '{6700, 2500, 120, 81, 0, NoT},
        '{-6700, -2500, -120, 172, 0, NoT},
        '{4500, 18000, 840, 100, 0, NoT},
        '{-4500, -18000, -720, 200, 0, NoT},
        // latitude past the pole flips the sign of the denominator
        '{16383, 0, 0, 172, 0, NoT},
        '{16384, 0, 0, 300, 0, NoT},
        // longitude and offset values at the edges of their signed register fields
        '{0, 32767, 1024, 172, 0, NoT},
        '{0, 32768, 1023, 172, 0, NoT},
        '{1000, 65535, 2047, 50, 0, NoT}
    };

    initial begin
        int cur_lat, cur_lon, cur_utc, day;
        foreach (atan_q[i]) atan_q[i] = 0;
        atan_q[0] = 51472; atan_q[1] = 30386; atan_q[2] = 16055; atan_q[3] = 8150;
        atan_q[4] = 4091; atan_q[5] = 2047; atan_q[6] = 1024; atan_q[7] = 512;
        atan_q[8] = 256; atan_q[9] = 128; atan_q[10] = 64; atan_q[11] = 32;
        atan_q[12] = 16; atan_q[13] = 8; atan_q[14] = 4; atan_q[15] = 2; atan_q[16] = 1;
        errors = 0; mismatches = 0; beats_in = 0; beats_out = 0;
        polar_seen = 0; cfg_writes = 0;
        snd_pct = 38;
        rcv_pct = 67;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ssc_pkg::RegLat;
        i_cfg_data = '0;
        site_lat = 3990;
        site_lon = 3280;
        site_utc = 180;
        cur_lat = 3990; cur_lon = 3280; cur_utc = 180;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < NDir; i++) begin
            if (dir_tbl[i].lat != cur_lat || dir_tbl[i].lon != cur_lon ||
                dir_tbl[i].utc != cur_utc) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                set_site(dir_tbl[i].lat, dir_tbl[i].lon, dir_tbl[i].utc);
                cur_lat = dir_tbl[i].lat;
                cur_lon = dir_tbl[i].lon;
                cur_utc = dir_tbl[i].utc;
            end
            send_day(dir_tbl[i].day[8:0], dir_tbl[i].typed, dir_tbl[i].want);
            sender_gap();
        end

        for (int n = 0; n < NRand; n++) begin
            if (n == NRand / 3) begin
                snd_pct = 67;
                rcv_pct = 38;
            end else if (n == 2 * NRand / 3) begin
                snd_pct = 0;
                rcv_pct = 0;
            end
            // new site every 125 days, the extremes come up often
            if (n % 125 == 0) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                set_site(pick(-9000, 9000, 15), pick(-18000, 18000, 16), pick(-720, 840, 11));
            end
            if (n == 600) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                while (pending_times.size() != 0) @(negedge i_clk);
            end
            day = ($urandom_range(9) == 0) ? int'($urandom_range(511))
                                           : int'($urandom_range(1, 366));
            send_day(day[8:0], 1'b0, NoT);
            sender_gap();
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        rcv_pct = 0;
        while (pending_times.size() != 0) @(negedge i_clk);
        repeat (Latency + 20) @(negedge i_clk);

        $display("%0d days sent over %0d register writes, %0d results checked, %0d polar",
                 beats_in, cfg_writes, beats_out, polar_seen);
        $display("idle mixes sender/receiver 38/67, 67/38 and none, %0d errors", errors);
        if (errors == 0)
            $display("sunrise_sunset_calculator verification clean");
        else
            $display("sunrise_sunset_calculator verification failed");
        $finish;
    end

endmodule
